### rtl/h264_fua_pkg.sv
package h264_fua_pkg;

  // Largest payload of one packet, in bytes of NAL data
  localparam int unsigned MaxPayload = 1400;

  localparam int unsigned AddrWidth = 3;
  localparam logic [AddrWidth-1:0] CfgAddrTicks = 3'd0;

  localparam logic [16:0] TicksReset = 17'd3000;

  localparam logic [7:0] NalTypeMask = 8'h1F;
  localparam logic [7:0] NalNriMask  = 8'h60;
  localparam logic [7:0] FuStartBit  = 8'h80;
  localparam logic [7:0] FuEndBit    = 8'h40;
  localparam logic [4:0] FuAType     = 5'd28;
  localparam logic [4:0] NalTypeSps  = 5'd7;
  localparam logic [4:0] NalTypePps  = 5'd8;

  // One payload byte with its per-word framing flags
  typedef struct packed {
    logic [7:0] data;
    logic       pkt_first;
    logic       pkt_last;
    logic       run_last;
  } word_t;

  // Up to three words caused by one NAL byte, with the packet fields they share
  typedef struct packed {
    word_t [2:0] words;
    logic [1:0]  last_idx;
    logic [10:0] len;
    logic [15:0] seq;
    logic [31:0] ts;
  } bundle_t;

endpackage

### rtl/h264_fua_cfg.sv
module h264_fua_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [h264_fua_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [16:0]                         ticks_o
);

  logic [16:0] ticks_q;
  logic        hit;

  assign hit     = (paddr == h264_fua_pkg::CfgAddrTicks);
  assign pready  = 1'b1;
  assign prdata  = hit ? {15'd0, ticks_q} : 32'd0;
  assign ticks_o = ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= h264_fua_pkg::TicksReset;
    end else if (psel && penable && pwrite && hit) begin
      ticks_q <= pwdata[16:0];
    end
  end

endmodule

### rtl/h264_fua_core.sv
module h264_fua_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [7:0]            nal_byte_i,
  input  logic                  first_of_nal_i,
  input  logic [15:0]           nal_size_i,
  input  logic [16:0]           ticks_i,
  output logic                  emit_o,
  output h264_fua_pkg::bundle_t bundle_o
);

  logic [15:0] seq_q, seq_d;
  logic [31:0] time_q, time_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [15:0] left_q, left_d;
  logic [10:0] off_q, off_d;
  logic [15:0] idx_q, idx_d;
  logic        frag_q, frag_d;

  logic [7:0]  hdr;
  logic [10:0] off;
  logic [15:0] left;
  logic        frag;
  logic        active;
  logic        open_frag;
  logic [15:0] left_m1;
  logic [10:0] off_p1;
  logic [16:0] sum;
  logic [11:0] span;
  logic        frag_pl;
  logic [4:0]  nal_type;
  logic [7:0]  fu_hdr;

  // Header byte of a new NAL takes the place of the saved context
  assign hdr       = first_of_nal_i ? nal_byte_i : hdr_q;
  assign off       = first_of_nal_i ? 11'd0 : off_q;
  assign left      = first_of_nal_i ? nal_size_i : left_q;
  assign frag      = first_of_nal_i ? 1'b0 : frag_q;
  assign open_frag = first_of_nal_i && (nal_size_i > 16'(h264_fua_pkg::MaxPayload));
  assign active    = first_of_nal_i ? (nal_size_i != 16'd0) : (left_q != 16'd0);

  assign left_m1  = left - 16'd1;
  assign off_p1   = off + 11'd1;
  assign sum      = {1'b0, left} + {6'd0, off};
  assign span     = (sum > 17'(h264_fua_pkg::MaxPayload)) ?
                    12'(h264_fua_pkg::MaxPayload) : sum[11:0];
  assign frag_pl  = ({1'b0, off} + 12'd1 == 12'(h264_fua_pkg::MaxPayload)) ||
                    (left == 16'd1);
  assign nal_type = 5'(hdr & h264_fua_pkg::NalTypeMask);

  always_comb begin
    fu_hdr = hdr & h264_fua_pkg::NalTypeMask;
    if (idx_q == 16'd0) begin
      fu_hdr = fu_hdr | h264_fua_pkg::FuStartBit;
    end
    if (left <= 16'(h264_fua_pkg::MaxPayload)) begin
      fu_hdr = fu_hdr | h264_fua_pkg::FuEndBit;
    end
  end

  always_comb begin
    seq_d    = seq_q;
    time_d   = time_q;
    hdr_d    = hdr_q;
    left_d   = left_q;
    off_d    = off_q;
    idx_d    = idx_q;
    frag_d   = frag_q;
    emit_o   = 1'b0;
    bundle_o = '0;
    bundle_o.seq = seq_q;
    bundle_o.ts  = time_q;

    if (first_of_nal_i && active) begin
      hdr_d  = nal_byte_i;
      off_d  = 11'd0;
      idx_d  = 16'd0;
      frag_d = open_frag;
      left_d = open_frag ? nal_size_i - 16'd1 : nal_size_i;
    end

    if (active && !open_frag) begin
      emit_o = 1'b1;
      left_d = left_m1;
      off_d  = off_p1;
      if (!frag) begin
        bundle_o.len      = sum[10:0];
        bundle_o.last_idx = 2'd0;
        bundle_o.words[0] = '{data: nal_byte_i, pkt_first: (off == 11'd0),
                              pkt_last: (left == 16'd1), run_last: 1'b1};
        if (left_m1 == 16'd0) begin
          seq_d = seq_q + 16'd1;
          off_d = 11'd0;
          if (nal_type != h264_fua_pkg::NalTypeSps &&
              nal_type != h264_fua_pkg::NalTypePps) begin
            time_d = time_q + {15'd0, ticks_i};
          end
        end
      end else begin
        bundle_o.len = 11'(span + 12'd2);
        if (off == 11'd0) begin
          // Open a fragment: FU indicator, FU header, then the data byte
          bundle_o.last_idx = 2'd2;
          bundle_o.words[0] = '{data: (hdr & h264_fua_pkg::NalNriMask) |
                                      {3'd0, h264_fua_pkg::FuAType},
                                pkt_first: 1'b1, pkt_last: 1'b0, run_last: 1'b0};
          bundle_o.words[1] = '{data: fu_hdr, pkt_first: 1'b0, pkt_last: 1'b0,
                                run_last: 1'b0};
          bundle_o.words[2] = '{data: nal_byte_i, pkt_first: 1'b0,
                                pkt_last: frag_pl, run_last: 1'b1};
        end else begin
          bundle_o.last_idx = 2'd0;
          bundle_o.words[0] = '{data: nal_byte_i, pkt_first: 1'b0,
                                pkt_last: frag_pl, run_last: 1'b1};
        end
        if (frag_pl) begin
          seq_d = seq_q + 16'd1;
          off_d = 11'd0;
          idx_d = idx_q + 16'd1;
        end
        if (left_m1 == 16'd0) begin
          frag_d = 1'b0;
          idx_d  = 16'd0;
          time_d = time_q + {15'd0, ticks_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= '0;
      time_q <= '0;
      hdr_q  <= '0;
      left_q <= '0;
      off_q  <= '0;
      idx_q  <= '0;
      frag_q <= 1'b0;
    end else if (advance_i) begin
      seq_q  <= seq_d;
      time_q <= time_d;
      hdr_q  <= hdr_d;
      left_q <= left_d;
      off_q  <= off_d;
      idx_q  <= idx_d;
      frag_q <= frag_d;
    end
  end

endmodule

### rtl/h264_fua_outbuf.sv
module h264_fua_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  h264_fua_pkg::bundle_t bundle_i,
  output logic                  ready_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output h264_fua_pkg::word_t   word_o,
  output logic [10:0]           len_o,
  output logic [15:0]           seq_o,
  output logic [31:0]           ts_o
);

  h264_fua_pkg::bundle_t buf_q;
  logic                  valid_q;
  logic [1:0]            ptr_q;
  logic                  take;
  logic                  at_end;

  assign take        = valid_q && !out_stall_i;
  assign at_end      = (ptr_q == buf_q.last_idx);
  assign ready_o     = !valid_q || (take && at_end);
  assign out_valid_o = valid_q;
  assign len_o       = buf_q.len;
  assign seq_o       = buf_q.seq;
  assign ts_o        = buf_q.ts;

  always_comb begin
    case (ptr_q)
      2'd0:    word_o = buf_q.words[0];
      2'd1:    word_o = buf_q.words[1];
      default: word_o = buf_q.words[2];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      ptr_q   <= '0;
    end else if (take) begin
      if (at_end) begin
        valid_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= bundle_i;
    end
  end

endmodule

### rtl/h264_fu_a_packetizer.sv
// An accepted NAL byte passes the input register, then the result buffer,
// before its first result word shows.
// Throughput: one NAL byte per cycle while the receiver does not stall; a byte
// that opens an FU-A fragment drains 3 words, and the input stalls while they drain.
// Reset: rst_ni is asynchronous, active low; counters and context clear to
// zero, ticks_per_frame returns to 3000. No clearing pass follows reset.
module h264_fu_a_packetizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // NAL byte stream
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         nal_byte_i,
  input  logic                               first_of_nal_i,
  input  logic [15:0]                        nal_size_i,
  // RTP payload words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               packet_first_o,
  output logic                               packet_last_o,
  output logic [10:0]                        packet_length_o,
  output logic [15:0]                        sequence_number_o,
  output logic [31:0]                        rtp_timestamp_o,
  output logic                               run_last_o,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [h264_fua_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // Input register stage
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        first_q;
  logic [15:0] size_q;

  logic                  emit;
  logic                  buf_ready;
  logic                  advance;
  logic [16:0]           ticks;
  h264_fua_pkg::bundle_t bundle;
  h264_fua_pkg::word_t   word;

  // Retire the held byte when it makes no word, or when the buffer frees up
  assign advance    = in_valid_q && (!emit || buf_ready);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q  <= nal_byte_i;
      first_q <= first_of_nal_i;
      size_q  <= nal_size_i;
    end
  end

  h264_fua_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ticks_o (ticks)
  );

  // Packetizing decision and NAL context, updated as the byte retires
  h264_fua_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .nal_byte_i     (byte_q),
    .first_of_nal_i (first_q),
    .nal_size_i     (size_q),
    .ticks_i        (ticks),
    .emit_o         (emit),
    .bundle_o       (bundle)
  );

  // Result buffer: drain up to three words, one per cycle while the receiver does not stall
  h264_fua_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .bundle_i    (bundle),
    .ready_o     (buf_ready),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .word_o      (word),
    .len_o       (packet_length_o),
    .seq_o       (sequence_number_o),
    .ts_o        (rtp_timestamp_o)
  );

  assign out_byte_o     = word.data;
  assign packet_first_o = word.pkt_first;
  assign packet_last_o  = word.pkt_last;
  assign run_last_o     = word.run_last;

endmodule

### rtl/h264_fua_checker.sv
module h264_fua_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        packet_first_o,
  input logic        packet_last_o,
  input logic [10:0] packet_length_o,
  input logic [15:0] sequence_number_o,
  input logic [31:0] rtp_timestamp_o,
  input logic        run_last_o
);

  // A stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(packet_first_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  // Words of one byte's run follow back to back within the same packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o &&
      $stable(sequence_number_o) && $stable(rtp_timestamp_o) &&
      $stable(packet_length_o))
    else $error("run of words broken or packet fields changed");

  // A one-word packet has length one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_first_o && packet_last_o |-> packet_length_o == 11'd1)
    else $error("single-word packet with wrong length");

  // A packet's first word that does not end its run is an FU indicator and does not end the packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_first_o && !run_last_o |-> !packet_last_o &&
      out_byte_o[4:0] == h264_fua_pkg::FuAType)
    else $error("malformed FU indicator word");

  // Reset empties the output
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind h264_fu_a_packetizer h264_fua_checker u_h264_fua_checker (.*);

### verif/tb_h264_fu_a_packetizer.sv
`timescale 1ns / 1ps

module tb_h264_fu_a_packetizer;

  localparam int unsigned WatchdogLimit = 4000;  // cycles with no word moved on either side
  localparam int unsigned HoldOffCycles = 400;   // one long receiver hold-off
  localparam int unsigned DrainCycles   = 8;     // covers bytes left in the input register, with margin

  // One expected payload word with the packet fields it carries
  typedef struct packed {
    logic [7:0]  data;
    logic        pkt_first;
    logic        pkt_last;
    logic [10:0] len;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        run_last;
  } rtp_word_t;

  // Packetizer state mirror: turns each accepted NAL byte into the payload words it causes,
  // holds them in order and checks the words the block sends against them.
  class fua_scoreboard;
    logic [16:0]  ticks;
    logic [15:0]  seq;
    logic [31:0]  ts;
    logic [7:0]   hdr;
    int unsigned  left;
    int unsigned  offs;
    logic [15:0]  frag_idx;
    bit           fragmenting;
    rtp_word_t    words_due[$];
    int unsigned  errors;

    function new();
      ticks       = h264_fua_pkg::TicksReset;
      seq         = '0;
      ts          = '0;
      hdr         = '0;
      left        = 0;
      offs        = 0;
      frag_idx    = '0;
      fragmenting = 1'b0;
      errors      = 0;
    endfunction

    function void set_ticks(logic [16:0] value);
      ticks = value;
    endfunction

    function int unsigned pending();
      return words_due.size();
    endfunction

    function void push_word(logic [7:0] data, bit pf, bit pl, int unsigned len, bit rl);
      rtp_word_t w;
      w.data      = data;
      w.pkt_first = pf;
      w.pkt_last  = pl;
      w.len       = 11'(len);
      w.seq       = seq;
      w.ts        = ts;
      w.run_last  = rl;
      words_due.push_back(w);
    endfunction

    function void packetize_byte(logic [7:0] b, logic first, logic [15:0] size);
      int unsigned span;
      bit          pl;
      logic [7:0]  fu_hdr;
      if (first) begin
        if (size == 16'd0) return;
        hdr      = b;
        offs     = 0;
        frag_idx = '0;
        if (int'(size) > int'(h264_fua_pkg::MaxPayload)) begin
          fragmenting = 1'b1;
          left        = size - 1;
          return;
        end
        fragmenting = 1'b0;
        left        = size;
      end else if (left == 0) begin
        return;
      end

      if (!fragmenting) begin
        push_word(b, offs == 0, left == 1, offs + left, 1'b1);
        left--;
        offs++;
        if (left == 0) begin
          seq++;
          offs = 0;
          if (hdr[4:0] != h264_fua_pkg::NalTypeSps &&
              hdr[4:0] != h264_fua_pkg::NalTypePps) ts += 32'(ticks);
        end
        return;
      end

      span = offs + left;
      if (span > h264_fua_pkg::MaxPayload) span = h264_fua_pkg::MaxPayload;
      pl = (offs + 1 == h264_fua_pkg::MaxPayload) || (left == 1);
      if (offs == 0) begin
        fu_hdr = hdr & h264_fua_pkg::NalTypeMask;
        if (frag_idx == 16'd0) fu_hdr |= h264_fua_pkg::FuStartBit;
        if (left <= h264_fua_pkg::MaxPayload) fu_hdr |= h264_fua_pkg::FuEndBit;
        push_word((hdr & h264_fua_pkg::NalNriMask) | 8'(h264_fua_pkg::FuAType),
                  1'b1, 1'b0, span + 2, 1'b0);
        push_word(fu_hdr, 1'b0, 1'b0, span + 2, 1'b0);
      end
      push_word(b, 1'b0, pl, span + 2, 1'b1);
      left--;
      offs++;
      if (pl) begin
        seq++;
        offs = 0;
        frag_idx++;
      end
      if (left == 0) begin
        fragmenting = 1'b0;
        frag_idx    = '0;
        ts += 32'(ticks);
      end
    endfunction

    function void check_word(rtp_word_t got);
      rtp_word_t exp;
      if (words_due.size() == 0) begin
        $error("unexpected word: out_byte %0h seq %0d", got.data, got.seq);
        errors++;
        return;
      end
      exp = words_due.pop_front();
      if (got.data != exp.data) begin
        $error("out_byte: expected %0h, actual %0h", exp.data, got.data);
        errors++;
      end
      if (got.pkt_first != exp.pkt_first) begin
        $error("packet_first: expected %0d, actual %0d", exp.pkt_first, got.pkt_first);
        errors++;
      end
      if (got.pkt_last != exp.pkt_last) begin
        $error("packet_last: expected %0d, actual %0d", exp.pkt_last, got.pkt_last);
        errors++;
      end
      if (got.len != exp.len) begin
        $error("packet_length: expected %0d, actual %0d", exp.len, got.len);
        errors++;
      end
      if (got.seq != exp.seq) begin
        $error("sequence_number: expected %0d, actual %0d", exp.seq, got.seq);
        errors++;
      end
      if (got.ts != exp.ts) begin
        $error("rtp_timestamp: expected %0d, actual %0d", exp.ts, got.ts);
        errors++;
      end
      if (got.run_last != exp.run_last) begin
        $error("run_last: expected %0d, actual %0d", exp.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_stall_o;
  logic [7:0]                             nal_byte_i;
  logic                                   first_of_nal_i;
  logic [15:0]                            nal_size_i;
  logic                                   out_valid_o;
  logic                                   out_stall_i;
  logic [7:0]                             out_byte_o;
  logic                                   packet_first_o;
  logic                                   packet_last_o;
  logic [10:0]                            packet_length_o;
  logic [15:0]                            sequence_number_o;
  logic [31:0]                            rtp_timestamp_o;
  logic                                   run_last_o;
  logic                                   psel;
  logic                                   penable;
  logic                                   pwrite;
  logic [h264_fua_pkg::AddrWidth-1:0]     paddr;
  logic [31:0]                            pwdata;
  logic [31:0]                            prdata;
  logic                                   pready;

  fua_scoreboard sb = new();

  // Idle controls set by the sequence for the sender and the receiver, and the watchdog count
  bit          tx_bursts;
  bit          rx_bursts;
  bit          hold_off_req;
  int unsigned quiet_cycles;

  h264_fu_a_packetizer i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .nal_byte_i,
    .first_of_nal_i,
    .nal_size_i,
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .packet_first_o,
    .packet_last_o,
    .packet_length_o,
    .sequence_number_o,
    .rtp_timestamp_o,
    .run_last_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one NAL byte, optionally after an idle burst; hold it until the block takes it,
  // then let the mirror predict the words it causes.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] size);
    if (tx_bursts && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    nal_byte_i     <= b;
    first_of_nal_i <= first;
    nal_size_i     <= size;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.packetize_byte(b, first, size);
  endtask

  // Send a header byte and then body bytes with random data; the size on body bytes is
  // don't-care, so randomize it to toggle the bits the block must ignore.
  task automatic send_nal(input logic [7:0] hdr, input logic [15:0] size,
                          input int unsigned body);
    send_byte(hdr, 1'b1, size);
    for (int unsigned i = 0; i < body; i++) send_byte(8'($urandom), 1'b0, 16'($urandom));
  endtask

  // Drop valid, wait until every predicted word has come out, then cover bytes that
  // cause no word but may still sit in the input register.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value when pready is seen high.
  task automatic write_ticks(input logic [16:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= h264_fua_pkg::CfgAddrTicks;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_ticks(value);
  endtask

  // Mostly well-formed short NALs with random content; the rest is noise: stray bytes,
  // zero-size headers and NALs abandoned by an early restart, often with a fragmenting size.
  task automatic random_traffic(input int unsigned n_items, input bit quiet_tail);
    int unsigned sent;
    int unsigned body;
    logic [7:0]  hdr;
    logic [15:0] size;
    bit          calm;
    sent = 0;
    while (sent < n_items) begin
      calm      = quiet_tail && (n_items - sent < 40);
      tx_bursts = !calm && $urandom_range(0, 2) != 0;
      rx_bursts = !calm && $urandom_range(0, 2) != 0;
      hdr = 8'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        hdr[4:0] = $urandom_range(0, 1) ? h264_fua_pkg::NalTypeSps : h264_fua_pkg::NalTypePps;
      end
      case ($urandom_range(0, 9))
        0: begin
          // stray, or a continuation of an abandoned NAL
          send_byte(hdr, 1'b0, 16'($urandom));
        end
        1: begin
          send_byte(hdr, 1'b1, 16'd0);
        end
        2, 3: begin
          size = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(2, 12));
          body = $urandom_range(0, 3);
          send_nal(hdr, size, body);
          sent += body + 1;
        end
        default: begin
          size = 16'($urandom_range(1, 12));
          send_nal(hdr, size, size - 1);
          sent += size;
        end
      endcase
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so the block fills
  // and pushes back on the sender.
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Check every word the receiver takes
  always @(posedge clk_i) begin
    rtp_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.data      = out_byte_o;
      got.pkt_first = packet_first_o;
      got.pkt_last  = packet_last_o;
      got.len       = packet_length_o;
      got.seq       = sequence_number_o;
      got.ts        = rtp_timestamp_o;
      got.run_last  = run_last_o;
      sb.check_word(got);
    end
  end

  // Watchdog: restart the count whenever a word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_h264_fu_a_packetizer failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tx_bursts       = 1'b0;
    rx_bursts       = 1'b0;
    hold_off_req    = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    nal_byte_i     <= '0;
    first_of_nal_i <= 1'b0;
    nal_size_i     <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset value of ticks_per_frame, no idling
    send_nal(8'h65, 16'd1, 0);              // one-byte NAL, first and last together
    send_byte(8'hFF, 1'b0, 16'hFFFF);        // stray byte, no NAL open: drop
    send_byte(8'h67, 1'b1, 16'd0);           // zero size: no NAL opened
    send_byte(8'h67, 1'b1, 16'd3);           // SPS: timestamp holds
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_nal(8'h68, 16'd2, 1);               // PPS: timestamp holds
    send_byte(8'h41, 1'b1, 16'd10);          // early restart abandons this one
    send_byte(8'h12, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b1, 16'hFFFF);        // largest NAL: header gives no word,
    send_byte(8'hA5, 1'b0, 16'd0);           // next byte opens a fragment with start bit
    send_byte(8'h5A, 1'b0, 16'd0);
    send_byte(8'h07, 1'b1, 16'd1402);        // fragmented SPS, abandoned
    send_byte(8'h3C, 1'b0, 16'd0);
    send_nal(8'h01, 16'd4, 3);
    wait_idle();

    // Random traffic under the largest increment, opening with a long receiver hold-off
    write_ticks(17'd90000);
    hold_off_req = 1'b1;
    random_traffic(80, 1'b0);
    wait_idle();

    // Random increment, calm tail
    write_ticks(17'($urandom_range(1, 90000)));
    random_traffic(65, 1'b1);
    wait_idle();

    if (sb.errors == 0) begin
      $display("tb_h264_fu_a_packetizer passed");
    end else begin
      $display("tb_h264_fu_a_packetizer failed");
    end
    $finish;
  end

endmodule

### h264_fu_a_packetizer.f
rtl/h264_fua_pkg.sv
rtl/h264_fua_cfg.sv
rtl/h264_fua_core.sv
rtl/h264_fua_outbuf.sv
rtl/h264_fu_a_packetizer.sv
rtl/h264_fua_checker.sv
verif/tb_h264_fu_a_packetizer.sv
